/* hdl/vcs_pkg.sv */
package vcs_pkg;

    // request function codes (s_tuser)
    localparam logic [1:0] FUNC_STEP   = 2'd0;
    localparam logic [1:0] FUNC_RELOAD = 2'd1;
    localparam logic [1:0] FUNC_SNAP   = 2'd2;

    // chase mode codes
    localparam logic [7:0] MODE_SNAP      = 8'd0;
    localparam logic [7:0] MODE_CHASE     = 8'd1;
    localparam logic [7:0] MODE_LERP_FINE = 8'd2;
    localparam logic [7:0] MODE_LERP      = 8'd4;

    // bit cleared from the held mode on an unknown mode
    localparam logic [7:0] MODE_CLEAR_MASK = 8'hF7;

    // step counter
    localparam int         CNT_WIDTH    = 10;
    localparam logic [9:0] CNT_MAX_FINE = 10'h3FF;
    localparam logic [9:0] CNT_MAX      = 10'h0FF;

    // lerp weight totals
    localparam logic [10:0] WEIGHT_FINE = 11'h400;
    localparam logic [10:0] WEIGHT      = 11'h100;

    // per-axis operation codes
    localparam logic [1:0] AXIS_HOLD  = 2'd0;
    localparam logic [1:0] AXIS_SNAP  = 2'd1;
    localparam logic [1:0] AXIS_CHASE = 2'd2;
    localparam logic [1:0] AXIS_LERP  = 2'd3;

    // control from the sequencer to each axis unit
    typedef struct packed {
        logic [1:0]           op;
        logic                 fine;
        logic [CNT_WIDTH-1:0] weight;
    } axis_ctrl_t;

endpackage

/* hdl/vcs_axis.sv */
module vcs_axis #(
    parameter int COORD_WIDTH = 24
) (
    input  vcs_pkg::axis_ctrl_t             ctrl,
    input  logic signed [COORD_WIDTH-1:0]   view,
    input  logic signed [COORD_WIDTH-1:0]   target,
    output logic signed [COORD_WIDTH-1:0]   view_next
);

    localparam int W  = COORD_WIDTH;
    localparam int CW = W + 3;   // chase sum width
    localparam int PW = W + 12;  // product width
    localparam int SW = W + 13;  // lerp sum width

    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W:0]    diff;
    logic signed [W+1:0]  bias;
    logic signed [W+1:0]  step;
    logic signed [CW-1:0] chase_sum;
    logic signed [W-1:0]  chase_sat;

    logic signed [W-1:0]  lerp_a;
    logic signed [W-1:0]  lerp_b;
    logic [10:0]          comp;
    logic signed [PW-1:0] a_ext;
    logic signed [PW-1:0] b_ext;
    logic signed [PW-1:0] comp_ext;
    logic signed [PW-1:0] wt_ext;
    logic signed [PW-1:0] prod_a;
    logic signed [PW-1:0] prod_b;
    logic signed [SW-1:0] lerp_sum;
    logic signed [SW-1:0] lerp_round;
    logic signed [SW-1:0] lerp_quot;
    logic signed [W-1:0]  lerp_sat;
    logic signed [W:0]    near_diff;
    logic                 near;

    // chase: step by ceil(d/32) when positive, floor((d-31)/32) otherwise
    always_comb begin
        diff      = {target[W-1], target} - {view[W-1], view};
        bias      = (diff > 0) ? ({diff[W], diff} + (W+2)'(31))
                               : ({diff[W], diff} - (W+2)'(31));
        step      = bias >>> 5;
        chase_sum = {{3{view[W-1]}}, view} + {step[W+1], step};
        if (chase_sum[CW-1:W-1] == {(CW-W+1){chase_sum[CW-1]}}) begin
            chase_sat = chase_sum[W-1:0];
        end else begin
            chase_sat = chase_sum[CW-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // lerp: weighted sum of view and target, truncated toward zero by 256
    always_comb begin
        lerp_a   = ctrl.fine ? (view >>> 2) : view;
        lerp_b   = ctrl.fine ? (target >>> 2) : target;
        comp     = (ctrl.fine ? vcs_pkg::WEIGHT_FINE : vcs_pkg::WEIGHT) - {1'b0, ctrl.weight};
        a_ext    = {{(PW-W){lerp_a[W-1]}}, lerp_a};
        b_ext    = {{(PW-W){lerp_b[W-1]}}, lerp_b};
        comp_ext = {{(PW-11){1'b0}}, comp};
        wt_ext   = {{(PW-vcs_pkg::CNT_WIDTH){1'b0}}, ctrl.weight};
        prod_a   = a_ext * comp_ext;
        prod_b   = b_ext * wt_ext;
        lerp_sum = {prod_a[PW-1], prod_a} + {prod_b[PW-1], prod_b};
        lerp_round = lerp_sum[SW-1] ? (lerp_sum + SW'(255)) : lerp_sum;
        lerp_quot  = lerp_round >>> 8;
        if (lerp_quot[SW-1:W-1] == {(SW-W+1){lerp_quot[SW-1]}}) begin
            lerp_sat = lerp_quot[W-1:0];
        end else begin
            lerp_sat = lerp_quot[SW-1] ? SAT_MIN : SAT_MAX;
        end
        near_diff = {lerp_sat[W-1], lerp_sat} - {target[W-1], target};
        near      = (near_diff >= -128) && (near_diff <= 128);
    end

    // select the axis result
    always_comb begin
        unique case (ctrl.op)
            vcs_pkg::AXIS_HOLD:  view_next = view;
            vcs_pkg::AXIS_SNAP:  view_next = target;
            vcs_pkg::AXIS_CHASE: view_next = chase_sat;
            vcs_pkg::AXIS_LERP:  view_next = near ? target : lerp_sat;
            default:             view_next = view;
        endcase
    end

endmodule

/* hdl/viewport_chase_smoother.sv */
// channel   | signals                          | contents
// ----------+----------------------------------+--------------------------------------
// s_ (in)   | s_tvalid s_tready s_tdata s_tuser| target_x, target_y; tuser = func
// m_ (out)  | m_tvalid m_tready m_tdata        | view_x, view_y, mode_now
// cfg       | cfg_valid cfg_ready cfg_data     | load_chase_mode
//
// one request per cycle sustained while m_tready holds; a request goes through the input register,
// then one pass through the axis units into the result register
// the viewport, counter and mode feed back within that single pass
// reset (aresetn low, synchronous) clears the viewport, counter, modes and valids
// a stalled result holds m_tdata; s_tready drops only while both registers are full
module viewport_chase_smoother #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // target_x, target_y (lowest first), zero padded to bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // func
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // view_x, view_y, mode_now (lowest first), zero padded to bytes
    output logic [((2*COORD_WIDTH+15)/8)*8-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [7:0]                      cfg_data
);

    localparam int W      = COORD_WIDTH;
    localparam int MDATA  = ((2*W+15)/8)*8;
    localparam int MPAD   = MDATA - (2*W+8);

    logic                  in_valid_reg;
    logic [1:0]            in_func_reg;
    logic signed [W-1:0]   in_tx_reg;
    logic signed [W-1:0]   in_ty_reg;

    logic signed [W-1:0]   vx_reg;
    logic signed [W-1:0]   vy_reg;
    logic [vcs_pkg::CNT_WIDTH-1:0] cnt_reg;
    logic [vcs_pkg::CNT_WIDTH-1:0] cnt_next;
    logic [7:0]            mode_reg;
    logic [7:0]            mode_next;
    logic [7:0]            load_mode_reg;

    logic                  out_valid_reg;
    logic [MDATA-1:0]      out_data_reg;

    logic                  out_free;
    logic                  fire;
    vcs_pkg::axis_ctrl_t   ctrl;
    logic signed [W-1:0]   vx_next;
    logic signed [W-1:0]   vy_next;

    // handshakes
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_mode_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            load_mode_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_tx_reg   <= s_tdata[W-1:0];
            in_ty_reg   <= s_tdata[2*W-1:W];
        end
    end

    // sequencer: pick the axis operation, next counter and next mode
    always_comb begin
        ctrl.op     = vcs_pkg::AXIS_HOLD;
        ctrl.fine   = 1'b0;
        ctrl.weight = cnt_reg + 1'b1;
        cnt_next    = cnt_reg;
        mode_next   = mode_reg;
        unique case (in_func_reg)
            vcs_pkg::FUNC_STEP: begin
                unique case (mode_reg)
                    vcs_pkg::MODE_SNAP: begin
                        ctrl.op = vcs_pkg::AXIS_SNAP;
                    end
                    vcs_pkg::MODE_CHASE: begin
                        ctrl.op = vcs_pkg::AXIS_CHASE;
                    end
                    vcs_pkg::MODE_LERP_FINE: begin
                        if (cnt_reg < vcs_pkg::CNT_MAX_FINE) begin
                            ctrl.op   = vcs_pkg::AXIS_LERP;
                            ctrl.fine = 1'b1;
                            cnt_next  = cnt_reg + 1'b1;
                        end else begin
                            ctrl.op = vcs_pkg::AXIS_SNAP;
                        end
                    end
                    vcs_pkg::MODE_LERP: begin
                        if (cnt_reg < vcs_pkg::CNT_MAX) begin
                            ctrl.op  = vcs_pkg::AXIS_LERP;
                            cnt_next = cnt_reg + 1'b1;
                        end else begin
                            ctrl.op = vcs_pkg::AXIS_SNAP;
                        end
                    end
                    default: begin
                        ctrl.op   = vcs_pkg::AXIS_SNAP;
                        mode_next = mode_reg & vcs_pkg::MODE_CLEAR_MASK;
                    end
                endcase
            end
            vcs_pkg::FUNC_RELOAD: begin
                mode_next = load_mode_reg;
                cnt_next  = '0;
            end
            vcs_pkg::FUNC_SNAP: begin
                ctrl.op = vcs_pkg::AXIS_SNAP;
            end
            default: begin
                ctrl.op = vcs_pkg::AXIS_HOLD;
            end
        endcase
    end

    // axis datapaths
    vcs_axis #(.COORD_WIDTH(W)) u_axis_x (
        .ctrl      (ctrl),
        .view      (vx_reg),
        .target    (in_tx_reg),
        .view_next (vx_next)
    );

    vcs_axis #(.COORD_WIDTH(W)) u_axis_y (
        .ctrl      (ctrl),
        .view      (vy_reg),
        .target    (in_ty_reg),
        .view_next (vy_next)
    );

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vx_reg   <= '0;
            vy_reg   <= '0;
            cnt_reg  <= '0;
            mode_reg <= '0;
        end else if (fire) begin
            vx_reg   <= vx_next;
            vy_reg   <= vy_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {{MPAD{1'b0}}, mode_next, vy_next, vx_next};
        end
    end

endmodule

/* hdl/vcs_checker.sv */
module vcs_checker #(
    parameter int COORD_WIDTH = 24
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((2*COORD_WIDTH+15)/8)*8-1:0] m_tdata,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [7:0]                       cfg_data
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // requests stall only while a result is waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // a new result follows an accepted request through the input and result registers
    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a request");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind viewport_chase_smoother vcs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_vcs_checker (.*);

/* tb/viewport_chase_smoother_tb.sv */
`timescale 1ns / 100ps

module viewport_chase_smoother_tb;

    localparam int CW = 24;
    localparam int S_W = ((2*CW+7)/8)*8;
    localparam int M_W = ((2*CW+15)/8)*8;

    // func code the block ignores
    localparam logic [1:0] FUNC_IGNORED = 2'd3;

    // held modes that fall to the default branch, some with bit 3 set
    localparam logic [7:0] MODE_UNUSED            = 8'h03;
    localparam logic [7:0] MODE_SNAP_FLAGGED      = 8'h08;
    localparam logic [7:0] MODE_CHASE_FLAGGED     = 8'h09;
    localparam logic [7:0] MODE_LERP_FINE_FLAGGED = 8'h0A;
    localparam logic [7:0] MODE_LERP_FLAGGED      = 8'h0C;
    localparam logic [7:0] MODE_ALL_ONES          = 8'hFF;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 40;

    localparam longint COORD_MAX = (longint'(1) <<< (CW-1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [7:0]           mode;
    } view_t;

    // viewport predictor and queue of expected views
    class chase_scoreboard;
        longint     view_x;
        longint     view_y;
        logic [9:0] step_cnt;
        logic [7:0] held_mode;
        logic [7:0] load_mode;
        view_t      expected_views[$];
        int         mismatches;

        function new();
            view_x     = 0;
            view_y     = 0;
            step_cnt   = '0;
            held_mode  = vcs_pkg::MODE_SNAP;
            load_mode  = vcs_pkg::MODE_SNAP;
            mismatches = 0;
        endfunction

        function longint clamp_coord(longint v);
            if (v > COORD_MAX) return COORD_MAX;
            if (v < COORD_MIN) return COORD_MIN;
            return v;
        endfunction

        // 1/32 of the distance, rounded away from the viewport on a positive delta
        function longint chase_axis(longint v, longint t);
            longint d;
            longint s;
            d = t - v;
            s = (d > 0) ? ((d + 31) >>> 5) : ((d - 31) >>> 5);
            return clamp_coord(v + s);
        endfunction

        function longint near_snap(longint v, longint t);
            longint d;
            d = v - t;
            return (d >= -128 && d <= 128) ? t : v;
        endfunction

        function void step_toward(longint tx, longint ty);
            longint w;
            unique case (held_mode)
                vcs_pkg::MODE_SNAP: begin
                    view_x = tx;
                    view_y = ty;
                end
                vcs_pkg::MODE_CHASE: begin
                    view_x = chase_axis(view_x, tx);
                    view_y = chase_axis(view_y, ty);
                end
                vcs_pkg::MODE_LERP_FINE: begin
                    if (step_cnt < vcs_pkg::CNT_MAX_FINE) begin
                        step_cnt = step_cnt + 10'd1;
                        w = longint'(step_cnt);
                        view_x = clamp_coord(((view_x >>> 2)
                                              * (longint'(vcs_pkg::WEIGHT_FINE) - w)
                                              + (tx >>> 2) * w) / 256);
                        view_y = clamp_coord(((view_y >>> 2)
                                              * (longint'(vcs_pkg::WEIGHT_FINE) - w)
                                              + (ty >>> 2) * w) / 256);
                        view_x = near_snap(view_x, tx);
                        view_y = near_snap(view_y, ty);
                    end else begin
                        view_x = tx;
                        view_y = ty;
                    end
                end
                vcs_pkg::MODE_LERP: begin
                    if (step_cnt < vcs_pkg::CNT_MAX) begin
                        step_cnt = step_cnt + 10'd1;
                        w = longint'(step_cnt);
                        view_x = clamp_coord((view_x * (longint'(vcs_pkg::WEIGHT) - w)
                                              + tx * w) / 256);
                        view_y = clamp_coord((view_y * (longint'(vcs_pkg::WEIGHT) - w)
                                              + ty * w) / 256);
                        view_x = near_snap(view_x, tx);
                        view_y = near_snap(view_y, ty);
                    end else begin
                        view_x = tx;
                        view_y = ty;
                    end
                end
                default: begin
                    held_mode = held_mode & vcs_pkg::MODE_CLEAR_MASK;
                    view_x = tx;
                    view_y = ty;
                end
            endcase
        endfunction

        // accepted request: update the state and queue the view it leads to
        function void note_request(logic [1:0] func, logic signed [CW-1:0] tx_in,
                                   logic signed [CW-1:0] ty_in);
            longint tx;
            longint ty;
            view_t  v;
            tx = longint'(tx_in);
            ty = longint'(ty_in);
            unique case (func)
                vcs_pkg::FUNC_STEP:   step_toward(tx, ty);
                vcs_pkg::FUNC_RELOAD: begin
                    held_mode = load_mode;
                    step_cnt  = '0;
                end
                vcs_pkg::FUNC_SNAP: begin
                    view_x = tx;
                    view_y = ty;
                end
                default: ;
            endcase
            v.x    = view_x[CW-1:0];
            v.y    = view_y[CW-1:0];
            v.mode = held_mode;
            expected_views.push_back(v);
        endfunction

        // accepted result against the oldest expected view
        function void check_view(logic [M_W-1:0] data);
            view_t                exp_v;
            logic signed [CW-1:0] got_x;
            logic signed [CW-1:0] got_y;
            logic [7:0]           got_mode;
            got_x    = data[CW-1:0];
            got_y    = data[2*CW-1:CW];
            got_mode = data[2*CW+7:2*CW];
            if (expected_views.size() == 0) begin
                $error("unexpected result: view_x %0d view_y %0d mode_now %0d",
                       got_x, got_y, got_mode);
                mismatches++;
                return;
            end
            exp_v = expected_views.pop_front();
            if (got_x !== exp_v.x) begin
                $error("view_x: expected %0d, got %0d", exp_v.x, got_x);
                mismatches++;
            end
            if (got_y !== exp_v.y) begin
                $error("view_y: expected %0d, got %0d", exp_v.y, got_y);
                mismatches++;
            end
            if (got_mode !== exp_v.mode) begin
                $error("mode_now: expected %0d, got %0d", exp_v.mode, got_mode);
                mismatches++;
            end
        endfunction
    endclass

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;   // target_x, target_y
    logic [1:0]     s_tuser;   // func
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;   // view_x, view_y, mode_now
    logic           cfg_valid;
    logic           cfg_ready;
    logic [7:0]     cfg_data;

    chase_scoreboard sb;
    bit     gaps_on;
    bit     stalls_on;
    bit     hold_sink;
    longint tgt_x;
    longint tgt_y;
    int     idle_cycles;

    viewport_chase_smoother #(
        .COORD_WIDTH(CW)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // handshake monitor and watchdog
    always @(posedge aclk) begin
        bit busy;
        busy = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.load_mode = cfg_data;
                busy = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                sb.note_request(s_tuser, s_tdata[CW-1:0], s_tdata[2*CW-1:CW]);
                busy = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                sb.check_view(m_tdata);
                busy = 1'b1;
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("viewport_chase_smoother_tb failed");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        int w;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_sink = 1'b0;
            end
            w = stalls_on ? $urandom_range(0, 8) : 0;
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // one request, after a random gap
    task automatic send_request(logic [1:0] func, longint tx, longint ty);
        int gap;
        gap = gaps_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {ty[CW-1:0], tx[CW-1:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop offering and wait for every expected view
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_views.size() != 0) @(posedge aclk);
    endtask

    task automatic write_load_mode(logic [7:0] mode);
        drain();
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly a held or drifting target so the lerp and chase modes converge
    function automatic longint next_target(longint prev);
        int                   r;
        logic signed [CW-1:0] raw;
        longint               v;
        r = $urandom_range(0, 99);
        if (r < 55) return prev;
        if (r < 75) begin
            v = prev + longint'($urandom_range(0, 600)) - 300;
            return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
        end
        if (r < 93) begin
            raw = CW'($urandom);
            return longint'(raw);
        end
        case ($urandom_range(0, 3))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // load a mode, reload it, then random steps with some noise
    task automatic run_phase(logic [7:0] mode, int count, bit allow_reload);
        int         r;
        logic [1:0] func;
        write_load_mode(mode);
        gaps_on   = ($urandom_range(0, 2) != 0);
        stalls_on = ($urandom_range(0, 2) != 0);
        send_request(vcs_pkg::FUNC_RELOAD, tgt_x, tgt_y);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 86)      func = vcs_pkg::FUNC_STEP;
            else if (r < 90) func = allow_reload ? vcs_pkg::FUNC_RELOAD : vcs_pkg::FUNC_STEP;
            else if (r < 95) func = vcs_pkg::FUNC_SNAP;
            else             func = FUNC_IGNORED;
            tgt_x = next_target(tgt_x);
            tgt_y = next_target(tgt_y);
            send_request(func, tgt_x, tgt_y);
        end
    endtask

    // main sequence
    initial begin
        sb = new();
        idle_cycles = 0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        hold_sink = 1'b0;
        tgt_x = 0;
        tgt_y = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= vcs_pkg::FUNC_STEP;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // snap mode after reset, snap and ignored requests at the extremes
        send_request(vcs_pkg::FUNC_STEP, COORD_MAX, COORD_MIN);
        send_request(FUNC_IGNORED, 12345, -777);
        send_request(vcs_pkg::FUNC_SNAP, COORD_MIN, COORD_MAX);
        send_request(vcs_pkg::FUNC_RELOAD, 0, 0);
        send_request(vcs_pkg::FUNC_STEP, 0, 0);

        // chase: saturation at the low end, zero delta, small deltas, far target
        write_load_mode(vcs_pkg::MODE_CHASE);
        send_request(vcs_pkg::FUNC_RELOAD, 0, 0);
        send_request(vcs_pkg::FUNC_SNAP, COORD_MIN, COORD_MIN);
        send_request(vcs_pkg::FUNC_STEP, COORD_MIN, COORD_MIN);
        send_request(vcs_pkg::FUNC_SNAP, 100, 100);
        send_request(vcs_pkg::FUNC_STEP, 100, 100);
        send_request(vcs_pkg::FUNC_STEP, 101, -2000);
        send_request(vcs_pkg::FUNC_STEP, COORD_MAX, COORD_MIN);

        // lerp: near-target snap on both axes, then a far target
        write_load_mode(vcs_pkg::MODE_LERP);
        send_request(vcs_pkg::FUNC_RELOAD, 0, 0);
        send_request(vcs_pkg::FUNC_SNAP, 0, 0);
        send_request(vcs_pkg::FUNC_STEP, 100, -128);
        send_request(vcs_pkg::FUNC_STEP, COORD_MAX, COORD_MIN);
        send_request(vcs_pkg::FUNC_STEP, COORD_MAX, COORD_MIN);

        // fine lerp with negative and positive extremes
        write_load_mode(vcs_pkg::MODE_LERP_FINE);
        send_request(vcs_pkg::FUNC_RELOAD, 0, 0);
        send_request(vcs_pkg::FUNC_STEP, COORD_MIN, COORD_MAX);
        send_request(vcs_pkg::FUNC_STEP, COORD_MIN, COORD_MAX);

        // unknown modes clear bit 3
        write_load_mode(MODE_SNAP_FLAGGED);
        send_request(vcs_pkg::FUNC_RELOAD, 0, 0);
        send_request(vcs_pkg::FUNC_STEP, 5, 6);
        write_load_mode(MODE_ALL_ONES);
        send_request(vcs_pkg::FUNC_RELOAD, 0, 0);
        send_request(vcs_pkg::FUNC_STEP, -5, -6);

        // back-to-back requests against a long result stall, then a full drain
        gaps_on = 1'b0;
        hold_sink = 1'b1;
        for (int i = 0; i < 12; i++) begin
            tgt_x = next_target(tgt_x);
            tgt_y = next_target(tgt_y);
            send_request(vcs_pkg::FUNC_STEP, tgt_x, tgt_y);
        end
        drain();

        // random phases; the coarse lerp phase runs long enough to reach its counter limit
        run_phase(vcs_pkg::MODE_CHASE, 25, 1'b1);
        run_phase(vcs_pkg::MODE_LERP, 300, 1'b0);
        run_phase(vcs_pkg::MODE_LERP_FINE, 560, 1'b0);
        run_phase(vcs_pkg::MODE_SNAP, 25, 1'b1);
        run_phase(MODE_ALL_ONES, 25, 1'b1);
        run_phase(MODE_LERP_FLAGGED, 25, 1'b1);
        run_phase(MODE_CHASE_FLAGGED, 25, 1'b1);
        run_phase(MODE_LERP_FINE_FLAGGED, 25, 1'b1);
        run_phase(MODE_UNUSED, 25, 1'b1);
        run_phase(8'($urandom_range(0, 255)), 25, 1'b1);

        drain();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("viewport_chase_smoother_tb passed");
        end else begin
            $display("viewport_chase_smoother_tb failed");
        end
        $finish;
    end

endmodule
